>>> design/suif_pkg.sv
// ----------------------------------------------------------------------------
// suif_pkg
// Shared constants, operation codes and control structs of the event driven
// uart with idle line frame detection.
// ----------------------------------------------------------------------------
package suif_pkg;

    // buffer geometry
    localparam int BufDepth = 128;
    localparam int AddrW    = $clog2(BufDepth);
    localparam int CountW   = $clog2(BufDepth + 1);

    // fixed field widths
    localparam int OpW      = 3;
    localparam int ByteW    = 8;
    localparam int IdxW     = 7;
    localparam int LenW     = 8;
    localparam int IdleCfgW = 4;
    localparam int IdleCntW = 5;
    localparam int BitCntW  = 4;
    localparam int TxPhW    = 4;

    localparam logic [IdleCfgW-1:0] IdleTicksRst = IdleCfgW'(3);
    localparam logic [BitCntW-1:0]  RxBitsPerByte = BitCntW'(8);
    localparam logic [TxPhW-1:0]    TxLastData    = TxPhW'(8);
    localparam logic [IdleCntW-1:0] IdleCntMax    = '1;

    // request operation codes
    typedef enum logic [OpW-1:0] {
        OP_TICK       = 3'd0,
        OP_START      = 3'd1,
        OP_TX_WRITE   = 3'd2,
        OP_RX_READ    = 3'd3,
        OP_RX_RELEASE = 3'd4
    } t_op;

    // receive phase
    typedef enum logic [1:0] {
        RX_IDLE  = 2'd0,
        RX_ARMED = 2'd1,
        RX_RECV  = 2'd2
    } t_rx_phase;

    // decoded request, every strobe already qualified by acceptance
    typedef struct packed {
        logic              accepted;
        logic              tick;
        logic              start;
        logic              tx_write;
        logic              rx_read;
        logic              rx_release;
        logic              rx_pin;
        logic [ByteW-1:0]  tx_byte;
        logic              tx_last;
        logic [IdxW-1:0]   read_index;
    } t_cmd;

    // transmit side state after the request
    typedef struct packed {
        logic level;
        logic busy;
    } t_tx_stat;

    // receive side state after the request
    typedef struct packed {
        logic              ready;
        logic [LenW-1:0]   length;
        logic              read_fail;
    } t_rx_stat;

endpackage

>>> design/soft_uart_idle_frame.sv
// A result is valid in the cycle after its request is accepted.
// One request per cycle while the output is not stalled; the receive buffer
// read port is registered and delivers the byte of a read with its result.
// A stalled result in the output register holds off the next request; the
// next request enters in the cycle the result leaves. Reset clears all
// control state, sets idle_ticks to 3 and the line high; buffers not cleared.
// ----------------------------------------------------------------------------
// soft_uart_idle_frame
// Top level: request decode, idle_ticks register, output register and the
// valid/stall handshakes around the transmit and receive sides.
// ----------------------------------------------------------------------------
module soft_uart_idle_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [suif_pkg::OpW-1:0]      i_operation,
    input  logic                          i_rx_pin,
    input  logic [suif_pkg::ByteW-1:0]    i_tx_byte,
    input  logic                          i_tx_last,
    input  logic [suif_pkg::IdxW-1:0]     i_read_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_tx_pin,
    output logic [suif_pkg::ByteW-1:0]    o_rx_byte,
    output logic                          o_frame_ready,
    output logic [suif_pkg::LenW-1:0]     o_frame_length,
    output logic                          o_tx_busy,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic [suif_pkg::IdleCfgW-1:0] i_cfg_wdata
);
    import suif_pkg::*;

    logic                r_out_valid;
    logic                r_tx_pin;
    logic                r_frame_ready;
    logic [LenW-1:0]     r_frame_length;
    logic                r_tx_busy;
    logic                r_status;
    logic [IdleCfgW-1:0] r_idle_ticks;
    logic                accept;
    t_cmd                cmd;
    t_tx_stat            tx_stat;
    t_rx_stat            rx_stat;

    // handshake
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // request decode
    always_comb begin
        cmd            = '0;
        cmd.accepted   = accept;
        cmd.rx_pin     = i_rx_pin;
        cmd.tx_byte    = i_tx_byte;
        cmd.tx_last    = i_tx_last;
        cmd.read_index = i_read_index;
        if (accept) begin
            unique case (i_operation)
                OP_TICK:       cmd.tick       = 1'b1;
                OP_START:      cmd.start      = 1'b1;
                OP_TX_WRITE:   cmd.tx_write   = 1'b1;
                OP_RX_READ:    cmd.rx_read    = 1'b1;
                OP_RX_RELEASE: cmd.rx_release = 1'b1;
                default:       cmd.tick       = 1'b0;
            endcase
        end
    end

    // idle gap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= IdleTicksRst;
        end else if (i_cfg_we) begin
            r_idle_ticks <= i_cfg_wdata;
        end
    end

    suif_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (tx_stat)
    );

    suif_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_idle_ticks (r_idle_ticks),
        .o_stat       (rx_stat),
        .o_rx_byte    (o_rx_byte)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_pin       <= tx_stat.level;
            r_tx_busy      <= tx_stat.busy;
            r_frame_ready  <= rx_stat.ready;
            r_frame_length <= rx_stat.length;
            r_status       <= rx_stat.read_fail;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tx_pin       = r_tx_pin;
    assign o_frame_ready  = r_frame_ready;
    assign o_frame_length = r_frame_length;
    assign o_tx_busy      = r_tx_busy;
    assign o_status       = r_status;

endmodule

>>> design/suif_tx.sv
// ----------------------------------------------------------------------------
// suif_tx
// Transmit buffer memory and 8n1 bit sequencer. The byte at the current
// position is prefetched from the memory every cycle.
// ----------------------------------------------------------------------------
module suif_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  suif_pkg::t_cmd     i_cmd,
    output suif_pkg::t_tx_stat o_stat
);
    import suif_pkg::*;

    logic [ByteW-1:0]  r_mem [BufDepth];
    logic [ByteW-1:0]  r_rdata;
    logic [CountW-1:0] r_len, n_len;
    logic [CountW-1:0] r_pos, n_pos;
    logic [TxPhW-1:0]  r_phase, n_phase;
    logic [CountW-1:0] r_load, n_load;
    logic              r_level, n_level;
    logic              sending;
    logic              mem_we;
    logic [2:0]        bit_sel;

    assign sending = (r_pos < r_len);
    assign bit_sel = 3'(r_phase - TxPhW'(1));

    // sequencer and buffer load
    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_load  = r_load;
        n_level = r_level;
        mem_we  = 1'b0;
        if (i_cmd.tick && sending) begin
            if (r_phase == '0) begin
                n_level = 1'b0;
                n_phase = TxPhW'(1);
            end else if (r_phase <= TxLastData) begin
                n_level = r_rdata[bit_sel];
                n_phase = r_phase + TxPhW'(1);
            end else begin
                n_level = 1'b1;
                n_pos   = r_pos + CountW'(1);
                n_phase = '0;
            end
        end
        if (i_cmd.tx_write) begin
            // first byte of a load aborts any frame in flight
            if (r_load == '0) begin
                n_len   = '0;
                n_pos   = '0;
                n_phase = '0;
            end
            if (r_load < CountW'(BufDepth)) begin
                mem_we = 1'b1;
                n_load = r_load + CountW'(1);
            end
            if (i_cmd.tx_last) begin
                n_len   = n_load;
                n_pos   = '0;
                n_phase = '0;
                n_load  = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pos   <= '0;
            r_phase <= '0;
            r_load  <= '0;
            r_level <= 1'b1;
        end else begin
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_load  <= n_load;
            r_level <= n_level;
        end
    end

    // buffer memory, read port follows the send position
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_load[AddrW-1:0]] <= i_cmd.tx_byte;
        end
        r_rdata <= r_mem[r_pos[AddrW-1:0]];
    end

    assign o_stat.level = n_level;
    assign o_stat.busy  = (n_pos < n_len);

endmodule

>>> design/suif_rx.sv
// ----------------------------------------------------------------------------
// suif_rx
// Receive shifter, idle gap frame detector and receive buffer memory with a
// registered read port for byte reads.
// ----------------------------------------------------------------------------
module suif_rx (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  suif_pkg::t_cmd                i_cmd,
    input  logic [suif_pkg::IdleCfgW-1:0] i_idle_ticks,
    output suif_pkg::t_rx_stat            o_stat,
    output logic [suif_pkg::ByteW-1:0]    o_rx_byte
);
    import suif_pkg::*;

    logic [ByteW-1:0]    r_mem [BufDepth];
    logic [ByteW-1:0]    r_rdata;
    logic                r_rd_ok;
    t_rx_phase           r_phase, n_phase;
    logic [BitCntW-1:0]  r_bits, n_bits;
    logic [ByteW-1:0]    r_shift, n_shift;
    logic [CountW-1:0]   r_count, n_count;
    logic                r_seen, n_seen;
    logic                r_ready, n_ready;
    logic [IdleCntW-1:0] r_idle, n_idle;
    logic                byte_done;
    logic                mem_we;
    logic                rd_ok;

    // a byte completes on the eighth sample
    assign byte_done = i_cmd.tick && (r_phase == RX_RECV)
                       && ((r_bits + BitCntW'(1)) >= RxBitsPerByte);

    // phase next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            RX_ARMED: begin
                if (i_cmd.tick) n_phase = RX_RECV;
            end
            RX_RECV: begin
                if (byte_done) n_phase = RX_IDLE;
            end
            default: begin
                if (i_cmd.start) n_phase = RX_ARMED;
            end
        endcase
    end

    // shifter, counters and frame flags
    always_comb begin
        n_bits  = r_bits;
        n_shift = r_shift;
        n_count = r_count;
        n_seen  = r_seen;
        n_ready = r_ready;
        n_idle  = r_idle;
        mem_we  = 1'b0;
        if (i_cmd.tick) begin
            if (r_phase == RX_RECV) begin
                n_shift = {i_cmd.rx_pin, r_shift[ByteW-1:1]};
                n_bits  = r_bits + BitCntW'(1);
                if (byte_done) begin
                    if (r_count < CountW'(BufDepth)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CountW'(1);
                    end
                    n_seen = 1'b1;
                end
            end else if (r_phase != RX_ARMED && r_seen && !r_ready) begin
                if (r_idle != IdleCntMax) n_idle = r_idle + IdleCntW'(1);
                if (n_idle > IdleCntW'(i_idle_ticks)) begin
                    n_seen  = 1'b0;
                    n_ready = 1'b1;
                end
            end
        end
        if (i_cmd.start && r_phase != RX_ARMED && r_phase != RX_RECV) begin
            n_bits  = '0;
            n_shift = '0;
            n_idle  = '0;
            n_ready = 1'b0;
        end
        if (i_cmd.rx_release) begin
            n_count = '0;
            n_ready = 1'b0;
        end
    end

    assign rd_ok = r_ready && (CountW'(i_cmd.read_index) < r_count);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_IDLE;
            r_bits  <= '0;
            r_shift <= '0;
            r_count <= '0;
            r_seen  <= 1'b0;
            r_ready <= 1'b0;
            r_idle  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_ready <= n_ready;
            r_idle  <= n_idle;
            if (i_cmd.accepted) r_rd_ok <= i_cmd.rx_read && rd_ok;
        end
    end

    // buffer memory, read data held while the result waits
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AddrW-1:0]] <= n_shift;
        end
        if (i_cmd.rx_read) begin
            r_rdata <= r_mem[AddrW'(i_cmd.read_index)];
        end
    end

    assign o_stat.ready     = n_ready;
    assign o_stat.length    = LenW'(n_count);
    assign o_stat.read_fail = i_cmd.rx_read && !rd_ok;
    assign o_rx_byte        = r_rd_ok ? r_rdata : '0;

endmodule

>>> verif/tb_soft_uart_idle_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soft_uart_idle_frame
// Self-checking bench for the event driven uart with idle line frame detect.
// A directed table and random event sequences are driven with random gaps
// and output stalls. A cycle-free model of the transceiver predicts the
// results not fixed by hand, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_soft_uart_idle_frame;
    import suif_pkg::*;

    localparam int DataBits = 8;
    localparam logic [OpW-1:0] OpSpareLo = 3'd5;
    localparam logic [OpW-1:0] OpSpareHi = 3'd7;

    // one request as seen on the input ports
    typedef struct packed {
        logic [OpW-1:0]   op;
        logic             pin;
        logic [ByteW-1:0] data;
        logic             last;
        logic [IdxW-1:0]  idx;
    } t_uart_req;

    // one result as seen on the output ports
    typedef struct packed {
        logic             tx_pin;
        logic [ByteW-1:0] rx_byte;
        logic             frame_ready;
        logic [LenW-1:0]  frame_length;
        logic             tx_busy;
        logic             status;
    } t_line_result;

    // result fixed by hand for a directed request
    typedef struct packed {
        logic         pinned;
        t_line_result res;
    } t_pinned_result;

    typedef struct packed {
        t_uart_req    req;
        logic         pinned;
        t_line_result res;
    } t_req_row;

    localparam t_line_result ResNone    = '0;
    localparam t_line_result ResIdle    = '{1'b1, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0};
    localparam t_line_result ResNoFrame = '{1'b1, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OpW-1:0]      i_operation;
    logic                i_rx_pin;
    logic [ByteW-1:0]    i_tx_byte;
    logic                i_tx_last;
    logic [IdxW-1:0]     i_read_index;
    logic                o_valid;
    logic                i_stall;
    logic                o_tx_pin;
    logic [ByteW-1:0]    o_rx_byte;
    logic                o_frame_ready;
    logic [LenW-1:0]     o_frame_length;
    logic                o_tx_busy;
    logic                o_status;
    logic                i_cfg_we;
    logic [IdleCfgW-1:0] i_cfg_wdata;

    soft_uart_idle_frame u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_rx_pin       (i_rx_pin),
        .i_tx_byte      (i_tx_byte),
        .i_tx_last      (i_tx_last),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tx_pin       (o_tx_pin),
        .o_rx_byte      (o_rx_byte),
        .o_frame_ready  (o_frame_ready),
        .o_frame_length (o_frame_length),
        .o_tx_busy      (o_tx_busy),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // transceiver model state, reset values
    logic [IdleCfgW-1:0] idle_cfg  = 4'd3;
    t_rx_phase           rx_ph     = RX_IDLE;
    logic [3:0]          rx_bits   = '0;
    logic [ByteW-1:0]    rx_sr     = '0;
    logic [LenW-1:0]     rx_len    = '0;
    logic [ByteW-1:0]    rx_mem [BufDepth];
    logic                seen      = 1'b0;
    logic                ready     = 1'b0;
    logic [4:0]          idle_cnt  = '0;
    logic [ByteW-1:0]    tx_mem [BufDepth];
    logic [LenW-1:0]     tx_len    = '0;
    logic [LenW-1:0]     tx_pos    = '0;
    logic [3:0]          tx_ph     = '0;
    logic [LenW-1:0]     load_cnt  = '0;
    logic                tx_lvl    = 1'b1;

    t_line_result   line_results_due [$];
    t_pinned_result typed_results [$];
    int             mismatch_count = 0;
    int             events_sent = 0;
    int             send_calm = 0;
    int             recv_calm = 0;

    // directed requests, hand results only where obvious
    t_req_row directed_rows [25] = '{
        '{'{OP_RX_READ,    1'b0, 8'h00, 1'b0, 7'd0},   1'b1, ResNoFrame},
        '{'{OP_RX_RELEASE, 1'b1, 8'hff, 1'b1, 7'd127}, 1'b1, ResIdle},
        '{'{OpSpareHi,     1'b1, 8'hff, 1'b1, 7'd127}, 1'b1, ResIdle},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b1, ResIdle},
        '{'{OP_TX_WRITE,   1'b0, 8'hff, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TX_WRITE,   1'b0, 8'h00, 1'b1, 7'd0},   1'b0, ResNone},
        '{'{OP_START,      1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_START,      1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_RX_READ,    1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_TICK,       1'b1, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_RX_READ,    1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone},
        '{'{OP_RX_READ,    1'b1, 8'hff, 1'b1, 7'd127}, 1'b0, ResNone},
        '{'{OP_START,      1'b0, 8'h00, 1'b0, 7'd0},   1'b0, ResNone}
    };

    // one bit time of the transmitter
    function automatic void advance_tx_line();
        if (tx_pos >= tx_len || tx_pos >= BufDepth) return;
        if (tx_ph == 0) begin
            tx_lvl = 1'b0;
            tx_ph  = 4'd1;
        end else if (tx_ph <= DataBits) begin
            tx_lvl = tx_mem[tx_pos][tx_ph - 1];
            tx_ph  = tx_ph + 4'd1;
        end else begin
            tx_lvl = 1'b1;
            tx_pos = tx_pos + 8'd1;
            tx_ph  = '0;
        end
    endfunction

    // one bit time of the receiver and the idle gap counter
    function automatic void advance_rx_line(logic pin);
        case (rx_ph)
            RX_ARMED: begin
                rx_ph = RX_RECV;
            end
            RX_RECV: begin
                rx_sr = {pin, rx_sr[ByteW-1:1]};
                if (rx_bits < 4'd15) rx_bits = rx_bits + 4'd1;
                if (rx_bits >= DataBits) begin
                    if (rx_len < BufDepth) begin
                        rx_mem[rx_len] = rx_sr;
                        rx_len = rx_len + 8'd1;
                    end
                    seen  = 1'b1;
                    rx_ph = RX_IDLE;
                end
            end
            default: begin
                if (seen && !ready) begin
                    if (idle_cnt < 5'd31) idle_cnt = idle_cnt + 5'd1;
                    if (idle_cnt > idle_cfg) begin
                        seen  = 1'b0;
                        ready = 1'b1;
                    end
                end
            end
        endcase
    endfunction

    // state update and result of one accepted request
    function automatic t_line_result predict_uart_event(t_uart_req req);
        t_line_result res;
        res = '0;
        case (req.op)
            OP_TICK: begin
                advance_tx_line();
                advance_rx_line(req.pin);
            end
            OP_START: begin
                if (rx_ph == RX_IDLE) begin
                    rx_ph    = RX_ARMED;
                    rx_bits  = '0;
                    rx_sr    = '0;
                    idle_cnt = '0;
                    ready    = 1'b0;
                end
            end
            OP_TX_WRITE: begin
                // first write of a load drops any transmission in progress
                if (load_cnt == 0) begin
                    tx_len = '0;
                    tx_pos = '0;
                    tx_ph  = '0;
                end
                if (load_cnt < BufDepth) begin
                    tx_mem[load_cnt] = req.data;
                    load_cnt = load_cnt + 8'd1;
                end
                if (req.last) begin
                    tx_len   = load_cnt;
                    tx_pos   = '0;
                    tx_ph    = '0;
                    load_cnt = '0;
                end
            end
            OP_RX_READ: begin
                if (ready && req.idx < rx_len) res.rx_byte = rx_mem[req.idx];
                else res.status = 1'b1;
            end
            OP_RX_RELEASE: begin
                rx_len = '0;
                ready  = 1'b0;
            end
            default: ;
        endcase
        res.tx_pin       = tx_lvl;
        res.frame_ready  = ready;
        res.frame_length = rx_len;
        res.tx_busy      = (tx_pos < tx_len);
        return res;
    endfunction

    // wait draw for either side, with runs of no idling
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic t_uart_req make_req(logic [OpW-1:0] op);
        t_uart_req req;
        req.op   = op;
        req.pin  = 1'($urandom_range(0, 1));
        req.data = ByteW'($urandom);
        req.last = 1'($urandom_range(0, 1));
        req.idx  = IdxW'($urandom);
        return req;
    endfunction

    task automatic compare_result(t_line_result want);
        logic bad;
        bad = 1'b0;
        if (o_tx_pin !== want.tx_pin) begin
            $display("%0t: tx_pin expected %0h actual %0h", $time, want.tx_pin, o_tx_pin);
            bad = 1'b1;
        end
        if (o_rx_byte !== want.rx_byte) begin
            $display("%0t: rx_byte expected %0h actual %0h", $time, want.rx_byte, o_rx_byte);
            bad = 1'b1;
        end
        if (o_frame_ready !== want.frame_ready) begin
            $display("%0t: frame_ready expected %0h actual %0h", $time,
                     want.frame_ready, o_frame_ready);
            bad = 1'b1;
        end
        if (o_frame_length !== want.frame_length) begin
            $display("%0t: frame_length expected %0d actual %0d", $time,
                     want.frame_length, o_frame_length);
            bad = 1'b1;
        end
        if (o_tx_busy !== want.tx_busy) begin
            $display("%0t: tx_busy expected %0h actual %0h", $time, want.tx_busy, o_tx_busy);
            bad = 1'b1;
        end
        if (o_status !== want.status) begin
            $display("%0t: status expected %0h actual %0h", $time, want.status, o_status);
            bad = 1'b1;
        end
        if (bad) mismatch_count++;
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result checking and prediction at the rising edge
    always @(posedge i_clk) begin
        t_pinned_result pr;
        t_line_result   got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (line_results_due.size() == 0) begin
                    $display("%0t: result with no request pending", $time);
                    mismatch_count++;
                end else begin
                    compare_result(line_results_due.pop_front());
                end
            end
            if (i_valid && !o_stall) begin
                pr  = typed_results.pop_front();
                got = predict_uart_event('{i_operation, i_rx_pin, i_tx_byte, i_tx_last,
                                           i_read_index});
                line_results_due.push_back(pr.pinned ? pr.res : got);
            end
        end
    end

    // output side stalls, one draw per result
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            hold = pick_wait(recv_calm);
            @(negedge i_clk);
            i_stall <= (hold != 0);
            if (hold > 1) repeat (hold - 1) @(negedge i_clk);
            if (hold != 0) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // one request with a random gap ahead of it
    task automatic send_request(t_uart_req req, logic pinned, t_line_result want);
        int gap;
        gap = pick_wait(send_calm);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation  <= req.op;
        i_rx_pin     <= req.pin;
        i_tx_byte    <= req.data;
        i_tx_last    <= req.last;
        i_read_index <= req.idx;
        i_valid      <= 1'b1;
        typed_results.push_back('{pinned, want});
        do @(posedge i_clk); while (o_stall);
        events_sent++;
    endtask

    task automatic send_event(t_uart_req req);
        send_request(req, 1'b0, ResNone);
    endtask

    // idle_ticks write once nothing is in flight
    task automatic set_idle_ticks(logic [IdleCfgW-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (line_results_due.size() != 0 || typed_results.size() != 0)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        idle_cfg = value;
    endtask

    task automatic send_read(logic in_range);
        t_uart_req req;
        req = make_req(OP_RX_READ);
        if (in_range && rx_len != 0) req.idx = IdxW'($urandom_range(0, rx_len - 1));
        send_event(req);
    endtask

    // one start plus skip tick plus eight sampled ticks per byte
    task automatic receive_byte(logic mix_tx);
        send_event(make_req(OP_START));
        repeat (1 + DataBits) begin
            if (mix_tx && $urandom_range(0, 7) == 0) send_event(make_req(OP_TX_WRITE));
            send_event(make_req(OP_TICK));
        end
    endtask

    task automatic tx_load(int count, logic close);
        t_uart_req req;
        for (int i = 0; i < count; i++) begin
            req = make_req(OP_TX_WRITE);
            req.last = (i == count - 1) && (close || $urandom_range(0, 5) != 0);
            send_event(req);
        end
    endtask

    // frame of a few bytes, idle gap, reads, sometimes a release
    task automatic rx_frame_burst(int count);
        repeat (count) receive_byte(1'b1);
        repeat ($urandom_range(0, idle_cfg + 3)) send_event(make_req(OP_TICK));
        repeat ($urandom_range(0, 3)) send_read($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0) send_event(make_req(OP_RX_RELEASE));
    endtask

    task automatic random_events(int budget);
        int stop_at;
        stop_at = events_sent + budget;
        while (events_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: rx_frame_burst($urandom_range(1, 3));
                4, 5: tx_load($urandom_range(1, 6), 1'b0);
                6: repeat ($urandom_range(1, 24)) send_event(make_req(OP_TICK));
                7: repeat ($urandom_range(1, 4)) send_event(make_req(OpW'($urandom_range(0, 7))));
                8: begin
                    send_read(1'b1);
                    send_event(make_req(OP_RX_RELEASE));
                end
                default: begin
                    // broken byte: start then too few ticks before other events
                    send_event(make_req(OP_START));
                    repeat ($urandom_range(0, 7)) send_event(make_req(OP_TICK));
                    send_event(make_req(OpW'($urandom_range(OP_START, OpSpareLo))));
                end
            endcase
        end
    endtask

    // run the receive store past full and the transmit load past full
    task automatic fill_rx_store();
        t_uart_req req;
        for (int b = 0; b < BufDepth + 4; b++) begin
            receive_byte(1'b0);
            if (b % 16 == 15) begin
                repeat (idle_cfg + 2) send_event(make_req(OP_TICK));
                send_read(1'b1);
            end
            if (b == 40) tx_load(BufDepth + 2, 1'b1);
        end
        repeat (idle_cfg + 2) send_event(make_req(OP_TICK));
        req = make_req(OP_RX_READ);
        req.idx = IdxW'(BufDepth - 1);
        send_event(req);
        req.idx = '0;
        send_event(req);
        send_event(make_req(OP_RX_RELEASE));
        send_event(req);
    endtask

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_operation  = OP_TICK;
        i_rx_pin     = 1'b0;
        i_tx_byte    = '0;
        i_tx_last    = 1'b0;
        i_read_index = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].res);

        set_idle_ticks('0);
        random_events(250);
        set_idle_ticks('1);
        fill_rx_store();
        set_idle_ticks(IdleCfgW'($urandom_range(1, 14)));
        random_events(150);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (line_results_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
